>>> hdl/dfarx_pkg.sv
// Shared types and codes for the DFA longest-match block.
package dfarx_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_TRANS   = 2'd0,
        OP_LOAD_PATTERN = 2'd1,
        OP_LOAD_ACCEPT  = 2'd2,
        OP_CHAR         = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_RANGE = 2'd0,
        KIND_BEGIN = 2'd1,
        KIND_END   = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_op         op;
        logic [5:0]  table_state;
        logic [3:0]  table_pattern;
        logic [5:0]  table_next;
        logic        table_valid;
        t_kind       pattern_kind;
        logic [20:0] range_low;
        logic [20:0] range_high;
        logic        accept_flag;
        logic [20:0] char_code;
        logic        is_first;
        logic        is_last;
    } t_word;

    typedef struct packed {
        t_kind       kind;
        logic [20:0] low;
        logic [20:0] high;
    } t_pattern;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_eng_state;

endpackage

>>> hdl/dfarx_if.sv
// Valid/ready channel interfaces for input words and match results.
interface dfarx_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [5:0]  table_state;
    logic [3:0]  table_pattern;
    logic [5:0]  table_next;
    logic        table_valid;
    logic [1:0]  pattern_kind;
    logic [20:0] range_low;
    logic [20:0] range_high;
    logic        accept_flag;
    logic [20:0] char_code;
    logic        is_first;
    logic        is_last;

    modport source (
        output valid, op, table_state, table_pattern, table_next, table_valid,
               pattern_kind, range_low, range_high, accept_flag, char_code,
               is_first, is_last,
        input  ready
    );
    modport sink (
        input  valid, op, table_state, table_pattern, table_next, table_valid,
               pattern_kind, range_low, range_high, accept_flag, char_code,
               is_first, is_last,
        output ready
    );
endinterface

interface dfarx_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] match_length;

    modport source (output valid, found, match_length, input ready);
    modport sink (input valid, found, match_length, output ready);
endinterface

>>> hdl/dfarx_front.sv
// Input side: accept words, decode them and hold them in a two-entry queue.
module dfarx_front
    import dfarx_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    dfarx_in_if.sink      i_in,
    output t_word         o_word,
    output logic          o_valid,
    input  logic          i_pop
);

    t_word      r_q [2];
    logic       r_rd_ptr;
    logic       r_wr_ptr;
    logic [1:0] r_count;
    t_word      w_word;
    logic       w_push;
    logic       w_pop;

    assign i_in.ready = (r_count != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != 2'd0);
    assign o_valid    = (r_count != 2'd0);
    assign o_word     = r_q[r_rd_ptr];

    always_comb begin
        w_word.op            = t_op'(i_in.op);
        w_word.table_state   = i_in.table_state;
        w_word.table_pattern = i_in.table_pattern;
        w_word.table_next    = i_in.table_next;
        w_word.table_valid   = i_in.table_valid;
        w_word.pattern_kind  = t_kind'(i_in.pattern_kind);
        w_word.range_low     = i_in.range_low;
        w_word.range_high    = i_in.range_high;
        w_word.accept_flag   = i_in.accept_flag;
        w_word.char_code     = i_in.char_code;
        w_word.is_first      = i_in.is_first;
        w_word.is_last       = i_in.is_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_word;
        end
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/dfarx_engine.sv
// Match engine: table stores, step sequencer and result register.
module dfarx_engine
    import dfarx_pkg::*;
#(
    parameter int NUM_STATES        = 64,
    parameter int NUM_PATTERNS      = 16,
    parameter int MAX_WINDOW        = 65535,
    parameter int ANCHOR_STEP_LIMIT = 4
)(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_word         i_word,
    input  logic          i_valid,
    output logic          o_pop,
    input  logic          i_greedy,
    dfarx_out_if.source   o_out
);

    localparam int SW  = $clog2(NUM_STATES);
    localparam int PW  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int OW  = $clog2(MAX_WINDOW + 1);
    localparam int CW  = $clog2(ANCHOR_STEP_LIMIT + 1);

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] next;
    } t_edge;

    typedef t_edge t_row [NUM_PATTERNS];

    t_row            mem_tr [NUM_STATES];
    logic            mem_acc [NUM_STATES];
    logic            r_accv [NUM_STATES];
    t_pattern        r_pat [NUM_PATTERNS];

    t_eng_state      r_state, n_state;
    t_row            r_row;
    logic            r_acc_m;
    logic            r_acc_v;
    logic [SW-1:0]   r_cur, n_cur;
    logic [OW-1:0]   r_off, n_off;
    logic [OW-1:0]   r_rec, n_rec;
    logic            r_recv, n_recv;
    logic            r_done, n_done;
    logic            r_final, n_final;
    logic [CW-1:0]   r_steps, n_steps;
    logic [20:0]     r_char, n_char;
    logic            r_last, n_last;
    logic            r_out_valid;
    logic            r_found;
    logic [15:0]     r_len;

    logic            w_out_free;
    logic            w_acc;
    logic            w_hit;
    logic            w_cons;
    logic [SW-1:0]   w_hit_next;
    logic            w_emit;
    logic            w_emit_found;
    logic [OW-1:0]   w_emit_len;
    logic            w_stop;
    logic [NUM_PATTERNS-1:0] w_fit;
    logic            w_ld_state_ok;
    logic            w_ld_pat_ok;
    logic            w_char_start;

    assign w_out_free    = !r_out_valid || o_out.ready;
    assign w_acc         = r_acc_m && r_acc_v;
    assign w_ld_state_ok = (32'(i_word.table_state) < NUM_STATES);
    assign w_ld_pat_ok   = (32'(i_word.table_pattern) < NUM_PATTERNS);
    assign o_pop         = (r_state == ST_IDLE);
    assign w_char_start  = i_valid && (i_word.op == OP_CHAR)
                           && (i_word.is_first || !r_done);

    always_comb begin
        for (int j = 0; j < NUM_PATTERNS; j++) begin
            case (r_pat[j].kind)
                KIND_RANGE: w_fit[j] = r_row[j].valid && (r_char >= r_pat[j].low)
                                       && (r_char <= r_pat[j].high);
                KIND_BEGIN: w_fit[j] = r_row[j].valid && (r_off == '0);
                KIND_END:   w_fit[j] = r_row[j].valid && r_last;
                default:    w_fit[j] = 1'b0;
            endcase
        end
        w_hit      = 1'b0;
        w_cons     = 1'b0;
        w_hit_next = '0;
        for (int j = NUM_PATTERNS - 1; j >= 0; j--) begin
            if (w_fit[j]) begin
                w_hit      = 1'b1;
                w_cons     = (r_pat[j].kind == KIND_RANGE);
                w_hit_next = r_row[j].next;
            end
        end
    end

    always_comb begin
        w_stop       = !w_hit || (!w_cons && (32'(r_steps) >= ANCHOR_STEP_LIMIT));
        w_emit       = 1'b0;
        w_emit_found = 1'b0;
        w_emit_len   = '0;
        if (r_state == ST_EVAL) begin
            if (r_final) begin
                w_emit       = 1'b1;
                w_emit_found = w_acc || r_recv;
                w_emit_len   = w_acc ? r_off : r_rec;
            end else if (w_acc) begin
                w_emit       = !i_greedy || w_stop;
                w_emit_found = 1'b1;
                w_emit_len   = r_off;
            end else if (w_stop) begin
                w_emit       = 1'b1;
                w_emit_found = r_recv;
                w_emit_len   = r_rec;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_char_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_EVAL;
            ST_EVAL: begin
                if (w_emit) begin
                    if (w_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (!w_cons || r_last) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cur   = r_cur;
        n_off   = r_off;
        n_rec   = r_rec;
        n_recv  = r_recv;
        n_done  = r_done;
        n_final = r_final;
        n_steps = r_steps;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            ST_IDLE: begin
                if (w_char_start) begin
                    n_char  = i_word.char_code;
                    n_last  = i_word.is_last;
                    n_final = 1'b0;
                    n_steps = '0;
                    if (i_word.is_first) begin
                        n_cur  = '0;
                        n_off  = '0;
                        n_rec  = '0;
                        n_recv = 1'b0;
                        n_done = 1'b0;
                    end
                end
            end
            ST_EVAL: begin
                if (w_emit) begin
                    if (w_out_free) begin
                        n_done = 1'b1;
                    end
                end else begin
                    if (w_acc) begin
                        n_rec  = r_off;
                        n_recv = 1'b1;
                    end
                    n_cur = w_hit_next;
                    if (w_cons) begin
                        if (32'(r_off) < MAX_WINDOW) begin
                            n_off = r_off + OW'(1);
                        end
                        n_final = r_last;
                    end else begin
                        n_steps = r_steps + CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_pop) begin
            case (i_word.op)
                OP_LOAD_TRANS: begin
                    if (w_ld_state_ok && w_ld_pat_ok) begin
                        mem_tr[SW'(i_word.table_state)][PW'(i_word.table_pattern)] <=
                            t_edge'{valid: i_word.table_valid
                                           && (32'(i_word.table_next) < NUM_STATES),
                                    next:  SW'(i_word.table_next)};
                    end
                end
                OP_LOAD_PATTERN: begin
                    if (w_ld_pat_ok) begin
                        r_pat[PW'(i_word.table_pattern)] <=
                            t_pattern'{kind: i_word.pattern_kind,
                                       low:  i_word.range_low,
                                       high: i_word.range_high};
                    end
                end
                OP_LOAD_ACCEPT: begin
                    if (w_ld_state_ok) begin
                        mem_acc[SW'(i_word.table_state)] <= i_word.accept_flag;
                    end
                end
                default: ;
            endcase
        end
        r_row   <= mem_tr[r_cur];
        r_acc_m <= mem_acc[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STATES; s++) begin
                r_accv[s] <= 1'b0;
            end
        end else if (i_valid && o_pop && (i_word.op == OP_LOAD_ACCEPT) && w_ld_state_ok) begin
            r_accv[SW'(i_word.table_state)] <= 1'b1;
        end
        r_acc_v <= r_accv[r_cur];
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_last  <= n_last;
        if (w_emit && w_out_free) begin
            r_found <= w_emit_found;
            r_len   <= w_emit_found ? 16'(w_emit_len) : 16'd0;
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_off       <= '0;
            r_rec       <= '0;
            r_recv      <= 1'b0;
            r_done      <= 1'b1;
            r_final     <= 1'b0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_off   <= n_off;
            r_rec   <= n_rec;
            r_recv  <= n_recv;
            r_done  <= n_done;
            r_final <= n_final;
            r_steps <= n_steps;
            if (w_emit && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_found;
    assign o_out.match_length = r_len;

endmodule

>>> hdl/dfarx_if_top_placeholder.sv
// Greedy-mode configuration register for the DFA longest-match block.
module dfarx_cfg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    output logic o_greedy
);

    logic r_greedy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_greedy <= 1'b1;
        end else if (i_cfg_we) begin
            r_greedy <= i_cfg_data;
        end
    end

    assign o_greedy = r_greedy;

endmodule

>>> hdl/dfa_regex_longest_match_top.sv
// Top level of the DFA longest-match block.
//
// channel  dir  handshake      payload
// i_in     in   valid/ready    op, table and pattern fields, char_code, is_first, is_last
// o_out    out  valid/ready    found, match_length
// i_cfg_*  in   write enable   greedy_mode
//
// A load word is taken while the engine is idle. A character word goes through pop, row
// read and pattern evaluation for its consuming step; each anchor step and the end of window
// check go through row read and pattern evaluation again.
// A result that waits on o_out.ready holds the engine in pattern evaluation.
// Reset is synchronous; all stores but the accept flags are undefined until loaded.
// A two-entry queue keeps input accepted while the engine works or the result waits.
module dfa_regex_longest_match_top
    import dfarx_pkg::*;
#(
    parameter int NUM_STATES        = 64,
    parameter int NUM_PATTERNS      = 16,
    parameter int MAX_WINDOW        = 65535,
    parameter int ANCHOR_STEP_LIMIT = 4
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dfarx_in_if.sink    i_in,
    dfarx_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data
);

    t_word w_word;
    logic  w_valid;
    logic  w_pop;
    logic  w_greedy;

    dfarx_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_greedy   (w_greedy)
    );

    dfarx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_word  (w_word),
        .o_valid (w_valid),
        .i_pop   (w_pop)
    );

    dfarx_engine #(
        .NUM_STATES        (NUM_STATES),
        .NUM_PATTERNS      (NUM_PATTERNS),
        .MAX_WINDOW        (MAX_WINDOW),
        .ANCHOR_STEP_LIMIT (ANCHOR_STEP_LIMIT)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (w_word),
        .i_valid  (w_valid),
        .o_pop    (w_pop),
        .i_greedy (w_greedy),
        .o_out    (o_out)
    );

endmodule
